// ===== sv/c2s_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants, payload types and arctangent table for the spherical converter.
package c2s_pkg;

  // Coordinate width of the input fields and derived fixed-point widths
  localparam int unsigned COORD_WIDTH = 16;
  // Fraction bits added to the coordinates before the rotation stages
  localparam int unsigned FB = (COORD_WIDTH >= 31) ? 0 :
                               (((31 - COORD_WIDTH) > 8) ? 8 : (31 - COORD_WIDTH));
  // Rotation datapath width: scaled coordinate plus headroom for the CORDIC gain
  localparam int unsigned CX_W    = COORD_WIDTH + FB + 3;
  // Angle accumulator, 2^-32 of a turn per LSB
  localparam int unsigned ACC_W   = 32;
  // Sum of two squares
  localparam int unsigned R2_W    = 2 * COORD_WIDTH;
  // Square root radicand, root and partial remainder
  localparam int unsigned SQ_IN_W = R2_W + 2 * FB;
  localparam int unsigned RT_W    = SQ_IN_W / 2;
  localparam int unsigned RM_W    = RT_W + 3;
  // Output field width
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned ATAN_LEN = 24;

  // Output angle codes, 65536 is a full turn
  localparam logic [ANG_W-1:0] TURN_ZERO     = 16'h0000;
  localparam logic [ANG_W-1:0] TURN_QUARTER  = 16'h4000;
  localparam logic [ANG_W-1:0] TURN_HALF     = 16'h8000;
  localparam logic [ANG_W-1:0] TURN_3QUARTER = 16'hC000;

  // Accumulator constants: half turn and rounding offset for the top 16 bits
  localparam logic [ACC_W-1:0] ACC_HALF = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ACC_RND  = 32'h0000_8000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
  } c2s_in_t;

  typedef struct packed {
    logic [ANG_W-1:0] radius_out;
    logic [ANG_W-1:0] theta_out;
    logic [ANG_W-1:0] phi_out;
    logic             zero_vector;
  } c2s_out_t;

  // Sign and zero status of the input vector, carried down the pipeline
  typedef struct packed {
    logic zero;
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic z_zero;
    logic z_neg;
  } c2s_flags_t;

  // Side data that rides along the square root stages
  typedef struct packed {
    c2s_flags_t             flags;
    logic signed [CX_W-1:0] phi_x;
    logic signed [CX_W-1:0] phi_y;
    logic signed [CX_W-1:0] az;
  } c2s_side_t;

  // Side data that rides along the rotation stages
  typedef struct packed {
    c2s_flags_t       flags;
    logic [ANG_W-1:0] radius;
  } c2s_tail_t;

  // Arctangent of 2^-i in 2^-32 turn units
  function automatic logic [ACC_W-1:0] atan_ent(input int unsigned idx);
    logic [ACC_W-1:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/c2s_prep.sv =====
`timescale 1ns / 1ps
// Front end: squares, sign flags, scaled rotation inputs and square root radicands.
module c2s_prep (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  c2s_pkg::c2s_in_t                in_data_i,
  output logic                            vld_o,
  output logic [c2s_pkg::SQ_IN_W-1:0]     rho_sq_o,
  output logic [c2s_pkg::SQ_IN_W-1:0]     rad_sq_o,
  output c2s_pkg::c2s_side_t              side_o
);

  localparam int unsigned CW      = c2s_pkg::COORD_WIDTH;
  localparam int unsigned CX_W    = c2s_pkg::CX_W;
  localparam int unsigned R2_W    = c2s_pkg::R2_W;
  localparam int unsigned SQ_IN_W = c2s_pkg::SQ_IN_W;
  localparam int unsigned FB      = c2s_pkg::FB;

  logic signed [CW-1:0]   x_in, y_in, z_in;
  logic signed [R2_W-1:0] x_prod, y_prod, z_prod;
  logic signed [CX_W-1:0] x_scl, y_scl, z_scl;
  c2s_pkg::c2s_flags_t    flags_d;
  c2s_pkg::c2s_side_t     side_d;

  logic                   v1_q, v2_q;
  logic [R2_W-1:0]        x2_q, y2_q, z2_q;
  c2s_pkg::c2s_side_t     side1_q, side2_q;
  logic [R2_W-1:0]        rho2, sum3;
  logic [SQ_IN_W-1:0]     rho_sq_d, rad_sq_d, rho_sq_q, rad_sq_q;

  assign x_in = in_data_i.x_coord;
  assign y_in = in_data_i.y_coord;
  assign z_in = in_data_i.z_coord;

  // Square each coordinate
  assign x_prod = x_in * x_in;
  assign y_prod = y_in * y_in;
  assign z_prod = z_in * z_in;

  // Scale coordinates into the fixed-point rotation format
  assign x_scl = CX_W'(x_in) <<< FB;
  assign y_scl = CX_W'(y_in) <<< FB;
  assign z_scl = CX_W'(z_in) <<< FB;

  // Classify the vector and fold it into the right half plane
  always_comb begin
    flags_d.x_zero = (x_in == '0);
    flags_d.y_zero = (y_in == '0);
    flags_d.z_zero = (z_in == '0);
    flags_d.x_neg  = x_in[CW-1];
    flags_d.y_neg  = y_in[CW-1];
    flags_d.z_neg  = z_in[CW-1];
    flags_d.zero   = flags_d.x_zero & flags_d.y_zero & flags_d.z_zero;
    side_d.flags   = flags_d;
    side_d.phi_x   = flags_d.x_neg ? -x_scl : x_scl;
    side_d.phi_y   = flags_d.x_neg ? -y_scl : y_scl;
    side_d.az      = flags_d.z_neg ? -z_scl : z_scl;
  end

  // Sum the squares and line up both radicands
  assign rho2     = x2_q + y2_q;
  assign sum3     = rho2 + z2_q;
  assign rho_sq_d = SQ_IN_W'(rho2) << (2 * FB);
  assign rad_sq_d = SQ_IN_W'({sum3, 2'b00});

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q     <= $unsigned(x_prod);
      y2_q     <= $unsigned(y_prod);
      z2_q     <= $unsigned(z_prod);
      side1_q  <= side_d;
      rho_sq_q <= rho_sq_d;
      rad_sq_q <= rad_sq_d;
      side2_q  <= side1_q;
    end
  end

  assign vld_o    = v2_q;
  assign rho_sq_o = rho_sq_q;
  assign rad_sq_o = rad_sq_q;
  assign side_o   = side2_q;

endmodule

// ===== sv/c2s_sqrt.sv =====
`timescale 1ns / 1ps
// Two-lane pipelined square root, one root bit per stage, for rho and the radius.
module c2s_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [c2s_pkg::SQ_IN_W-1:0]   rho_sq_i,
  input  logic [c2s_pkg::SQ_IN_W-1:0]   rad_sq_i,
  input  c2s_pkg::c2s_side_t            side_i,
  output logic                          vld_o,
  output logic [c2s_pkg::RT_W-1:0]      rho_root_o,
  output logic [c2s_pkg::RT_W-1:0]      rad_root_o,
  output c2s_pkg::c2s_side_t            side_o
);

  localparam int unsigned SQ_IN_W = c2s_pkg::SQ_IN_W;
  localparam int unsigned RT_W    = c2s_pkg::RT_W;
  localparam int unsigned RM_W    = c2s_pkg::RM_W;
  localparam int unsigned LANES   = 2;

  logic [SQ_IN_W-1:0] sq_in  [LANES];
  logic [SQ_IN_W-1:0] sq_q   [LANES][RT_W-1];
  logic [RM_W-1:0]    rem_q  [LANES][RT_W-1];
  logic [RT_W-1:0]    root_q [LANES][RT_W];
  logic [RT_W-1:0]    vld_q;
  c2s_pkg::c2s_side_t side_q [RT_W];

  assign sq_in[0] = rho_sq_i;
  assign sq_in[1] = rad_sq_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RT_W-2:0], vld_i};
    end
  end

  // Carry side data alongside the root stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < RT_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Restoring digit recurrence: bring down two radicand bits, try root*4+1
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic [SQ_IN_W-1:0] sq_cur;
      logic [RM_W-1:0]    rem_cur, rem_sh, trial;
      logic [RT_W-1:0]    root_cur, root_nx;
      logic               ge;

      if (k == 0) begin : g_first
        assign sq_cur   = sq_in[l];
        assign rem_cur  = '0;
        assign root_cur = '0;
      end else begin : g_next
        assign sq_cur   = sq_q[l][k-1];
        assign rem_cur  = rem_q[l][k-1];
        assign root_cur = root_q[l][k-1];
      end

      assign rem_sh  = {rem_cur[RM_W-3:0], sq_cur[SQ_IN_W-1-2*k -: 2]};
      assign trial   = {1'b0, root_cur, 2'b01};
      assign ge      = (rem_sh >= trial);
      assign root_nx = {root_cur[RT_W-2:0], ge};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          root_q[l][k] <= root_nx;
        end
      end

      // Keep remainder and radicand only where a later stage needs them
      if (k < RT_W - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[l][k] <= ge ? (rem_sh - trial) : rem_sh;
            sq_q[l][k]  <= sq_cur;
          end
        end
      end
    end
  end

  assign vld_o      = vld_q[RT_W-1];
  assign rho_root_o = root_q[0][RT_W-1];
  assign rad_root_o = root_q[1][RT_W-1];
  assign side_o     = side_q[RT_W-1];

endmodule

// ===== sv/c2s_cordic.sv =====
`timescale 1ns / 1ps
// Unrolled vectoring CORDIC, two lanes (polar angle and azimuth), one stage per register.
module c2s_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic signed [c2s_pkg::CX_W-1:0]       th_x_i,
  input  logic signed [c2s_pkg::CX_W-1:0]       th_y_i,
  input  logic signed [c2s_pkg::CX_W-1:0]       ph_x_i,
  input  logic signed [c2s_pkg::CX_W-1:0]       ph_y_i,
  input  c2s_pkg::c2s_tail_t                    tail_i,
  output logic                                  vld_o,
  output logic signed [c2s_pkg::ACC_W-1:0]      th_acc_o,
  output logic signed [c2s_pkg::ACC_W-1:0]      ph_acc_o,
  output c2s_pkg::c2s_tail_t                    tail_o
);

  localparam int unsigned CX_W  = c2s_pkg::CX_W;
  localparam int unsigned ACC_W = c2s_pkg::ACC_W;
  localparam int unsigned LANES = 2;

  logic signed [CX_W-1:0]  x_in  [LANES];
  logic signed [CX_W-1:0]  y_in  [LANES];
  logic signed [CX_W-1:0]  x_q   [LANES][STAGES-1];
  logic signed [CX_W-1:0]  y_q   [LANES][STAGES-1];
  logic signed [ACC_W-1:0] acc_q [LANES][STAGES];
  logic [STAGES-1:0]       vld_q;
  c2s_pkg::c2s_tail_t      tail_q [STAGES];

  assign x_in[0] = th_x_i;
  assign y_in[0] = th_y_i;
  assign x_in[1] = ph_x_i;
  assign y_in[1] = ph_y_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], vld_i};
    end
  end

  // Carry radius and flags alongside the rotation stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tail_q[0] <= tail_i;
      for (int k = 1; k < STAGES; k++) begin
        tail_q[k] <= tail_q[k-1];
      end
    end
  end

  // Rotate toward the x axis; the sign of y picks the direction
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [ACC_W-1:0] ATAN_I = c2s_pkg::atan_ent(i);
      logic signed [CX_W-1:0]  x_cur, y_cur;
      logic signed [ACC_W-1:0] acc_cur, acc_nx;

      if (i == 0) begin : g_first
        assign x_cur   = x_in[l];
        assign y_cur   = y_in[l];
        assign acc_cur = '0;
      end else begin : g_next
        assign x_cur   = x_q[l][i-1];
        assign y_cur   = y_q[l][i-1];
        assign acc_cur = acc_q[l][i-1];
      end

      assign acc_nx = y_cur[CX_W-1] ? (acc_cur - ATAN_I) : (acc_cur + ATAN_I);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          acc_q[l][i] <= acc_nx;
        end
      end

      // The last stage only needs the angle
      if (i < STAGES - 1) begin : g_rot
        logic signed [CX_W-1:0] x_nx, y_nx;
        assign x_nx = y_cur[CX_W-1] ? (x_cur - (y_cur >>> i)) : (x_cur + (y_cur >>> i));
        assign y_nx = y_cur[CX_W-1] ? (y_cur + (x_cur >>> i)) : (y_cur - (x_cur >>> i));
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            x_q[l][i] <= x_nx;
            y_q[l][i] <= y_nx;
          end
        end
      end
    end
  end

  assign vld_o    = vld_q[STAGES-1];
  assign th_acc_o = acc_q[0][STAGES-1];
  assign ph_acc_o = acc_q[1][STAGES-1];
  assign tail_o   = tail_q[STAGES-1];

endmodule

// ===== sv/cartesian_to_spherical.sv =====
`timescale 1ns / 1ps
// Top level of the Cartesian to spherical converter: pipeline, final angle logic, output skid.
// Converts a signed 16-bit vector (x, y, z) into its rounded radius, the polar angle
// theta from +z and the azimuth phi, both as unsigned fractions of a turn (65536 is a
// full turn, 32768 is pi). One item is accepted every clock while the skid entry is empty.
// From acceptance to out_valid_o an item passes two front-end stages for the squares
// and sums, 24 stages of the bit-per-stage square root that produces rho and the
// radius, CORDIC_STAGES rotation stages, one stage for angle folding and clamping, and the
// output register. A one-entry skid stage sits behind the output register, so the block
// keeps accepting while a result waits; the pipeline freezes only while that skid entry
// is occupied, and in_ready_o comes straight from a flip-flop. The zero vector gives
// radius 0, theta 0, phi 16384 and sets zero_vector.
module cartesian_to_spherical #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  c2s_pkg::c2s_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output c2s_pkg::c2s_out_t  out_data_o
);

  localparam int unsigned CX_W    = c2s_pkg::CX_W;
  localparam int unsigned ACC_W   = c2s_pkg::ACC_W;
  localparam int unsigned SQ_IN_W = c2s_pkg::SQ_IN_W;
  localparam int unsigned RT_W    = c2s_pkg::RT_W;
  localparam int unsigned ANG_W   = c2s_pkg::ANG_W;
  localparam logic signed [ACC_W:0] HALF_S = {1'b0, c2s_pkg::ACC_HALF};

  logic                    pipe_en;

  logic                    prep_vld;
  logic [SQ_IN_W-1:0]      rho_sq, rad_sq;
  c2s_pkg::c2s_side_t      prep_side;

  logic                    sq_vld;
  logic [RT_W-1:0]         rho_root, rad_root;
  c2s_pkg::c2s_side_t      sq_side;

  logic [RT_W:0]           rad_rnd;
  c2s_pkg::c2s_tail_t      tail_in;
  logic signed [CX_W-1:0]  th_y;

  logic                    cor_vld;
  logic signed [ACC_W-1:0] th_acc, ph_acc;
  c2s_pkg::c2s_tail_t      cor_tail;

  logic signed [ACC_W:0]   acc_ext, t_raw;
  logic [ACC_W-1:0]        t_clamp, phi_sum;
  logic                    fin_vld_q;
  c2s_pkg::c2s_tail_t      fin_tail_q;
  logic [ACC_W-1:0]        fin_t_q, fin_phi_q;

  logic [ACC_W-1:0]        theta_rnd, phi_rnd;
  c2s_pkg::c2s_out_t       res;

  logic                    out_valid_q, out_valid_d;
  logic                    skid_valid_q, skid_valid_d;
  c2s_pkg::c2s_out_t       out_q, skid_q;
  logic                    out_load, skid_load;

  // Freeze the pipeline only while the skid entry is occupied
  assign pipe_en    = ~skid_valid_q;
  assign in_ready_o = pipe_en;

  c2s_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .vld_i     (in_valid_i),
    .in_data_i (in_data_i),
    .vld_o     (prep_vld),
    .rho_sq_o  (rho_sq),
    .rad_sq_o  (rad_sq),
    .side_o    (prep_side)
  );

  c2s_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .vld_i      (prep_vld),
    .rho_sq_i   (rho_sq),
    .rad_sq_i   (rad_sq),
    .side_i     (prep_side),
    .vld_o      (sq_vld),
    .rho_root_o (rho_root),
    .rad_root_o (rad_root),
    .side_o     (sq_side)
  );

  // Round the radius: root of 4*s, plus one, halved
  assign rad_rnd       = {1'b0, rad_root} + (RT_W+1)'(1);
  assign tail_in.flags  = sq_side.flags;
  assign tail_in.radius = rad_rnd[ANG_W:1];
  assign th_y           = $signed(CX_W'(rho_root));

  c2s_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .vld_i    (sq_vld),
    .th_x_i   (sq_side.az),
    .th_y_i   (th_y),
    .ph_x_i   (sq_side.phi_x),
    .ph_y_i   (sq_side.phi_y),
    .tail_i   (tail_in),
    .vld_o    (cor_vld),
    .th_acc_o (th_acc),
    .ph_acc_o (ph_acc),
    .tail_o   (cor_tail)
  );

  // Fold the polar angle below the xy plane, clamp to [0, pi]; add pi to the azimuth for x < 0
  always_comb begin
    acc_ext = {th_acc[ACC_W-1], th_acc};
    t_raw   = cor_tail.flags.z_neg ? (HALF_S - acc_ext) : acc_ext;
    if (t_raw[ACC_W]) begin
      t_clamp = '0;
    end else if (t_raw > HALF_S) begin
      t_clamp = c2s_pkg::ACC_HALF;
    end else begin
      t_clamp = t_raw[ACC_W-1:0];
    end
    phi_sum = $unsigned(ph_acc) + (cor_tail.flags.x_neg ? c2s_pkg::ACC_HALF : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (pipe_en) begin
      fin_vld_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fin_tail_q <= cor_tail;
      fin_t_q    <= t_clamp;
      fin_phi_q  <= phi_sum;
    end
  end

  // Round the angles and apply the axis and plane cases
  assign theta_rnd = fin_t_q + c2s_pkg::ACC_RND;
  assign phi_rnd   = fin_phi_q + c2s_pkg::ACC_RND;

  always_comb begin
    res.radius_out  = fin_tail_q.radius;
    res.zero_vector = fin_tail_q.flags.zero;
    if (fin_tail_q.flags.zero) begin
      res.theta_out = c2s_pkg::TURN_ZERO;
    end else if (fin_tail_q.flags.x_zero && fin_tail_q.flags.y_zero) begin
      res.theta_out = fin_tail_q.flags.z_neg ? c2s_pkg::TURN_HALF : c2s_pkg::TURN_ZERO;
    end else if (fin_tail_q.flags.z_zero) begin
      res.theta_out = c2s_pkg::TURN_QUARTER;
    end else begin
      res.theta_out = theta_rnd[ACC_W-1 -: ANG_W];
    end
    if (fin_tail_q.flags.x_zero) begin
      res.phi_out = fin_tail_q.flags.y_neg ? c2s_pkg::TURN_3QUARTER : c2s_pkg::TURN_QUARTER;
    end else if (fin_tail_q.flags.y_zero) begin
      res.phi_out = fin_tail_q.flags.x_neg ? c2s_pkg::TURN_HALF : c2s_pkg::TURN_ZERO;
    end else begin
      res.phi_out = phi_rnd[ACC_W-1 -: ANG_W];
    end
  end

  // Output register with a one-entry skid behind it
  always_comb begin
    if (skid_valid_q) begin
      out_load     = out_ready_i;
      out_valid_d  = 1'b1;
      skid_load    = 1'b0;
      skid_valid_d = ~out_ready_i;
    end else begin
      out_load     = ~out_valid_q | out_ready_i;
      out_valid_d  = out_load ? fin_vld_q : out_valid_q;
      skid_load    = fin_vld_q & out_valid_q & ~out_ready_i;
      skid_valid_d = skid_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (skid_load) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A skid entry exists only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  // The skid fills only from a stalled output with a result arriving
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && fin_vld_q))
    else $error("skid filled without a stalled output");

  // A drained skid moves its item into the output register
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item lost on drain");

  // The zero vector gives its fixed result
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_vector) |->
      (out_data_o.radius_out == '0 && out_data_o.theta_out == c2s_pkg::TURN_ZERO &&
       out_data_o.phi_out == c2s_pkg::TURN_QUARTER))
    else $error("zero vector result is wrong");

  // The polar angle never exceeds pi
  a_theta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.theta_out <= c2s_pkg::TURN_HALF))
    else $error("theta beyond half turn");
`endif

endmodule
